[rtl/wsed_pkg.sv]
// Package with shared types and constants for the weighted squared distance block.
package wsed_pkg;

    localparam int unsigned MAX_CLUSTERS_DEF = 16;
    localparam int unsigned MAX_FEATURES_DEF = 64;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic REG_CLUSTER_COUNT = 1'b0;
    localparam logic REG_FEATURE_COUNT = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic        [5:0]  cluster_index;
        logic        [7:0]  feature_index;
        logic signed [15:0] value;
        logic        [15:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  result_cluster;
        logic [63:0] distance;
        logic        last_cluster;
    } out_item_t;

    typedef struct packed {
        logic               upd;
        logic               clr;
        logic signed [15:0] x;
        logic        [15:0] w;
    } cell_ctl_t;

endpackage

[rtl/wsed_ram.sv]
// Generic single-port-write, registered-read RAM.
module wsed_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/wsed_cell.sv]
// One cluster cell: center memory, squared-difference pipeline and accumulator.
module wsed_cell #(
    parameter int unsigned MAX_FEATURES = wsed_pkg::MAX_FEATURES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            we,
    input  logic [$clog2(MAX_FEATURES)-1:0] waddr,
    input  logic [15:0]                     wdata,
    input  logic [$clog2(MAX_FEATURES)-1:0] raddr,
    input  wsed_pkg::cell_ctl_t             ctl,
    input  logic                            shift,
    input  logic [63:0]                     shift_in,
    output logic [63:0]                     acc
);

    localparam int unsigned AW = $clog2(MAX_FEATURES);

    logic [15:0]        center;
    logic               upd_reg;
    logic               clr_reg;
    logic signed [15:0] x_reg;
    logic [15:0]        w_reg;
    logic               upd2_reg;
    logic               clr2_reg;
    logic [32:0]        sq_reg;
    logic [15:0]        w2_reg;
    logic signed [16:0] diff;
    logic [33:0]        sq_full;
    logic [48:0]        term;
    logic [64:0]        sum;
    logic [63:0]        acc_reg;
    logic [63:0]        acc_next;

    wsed_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (center)
    );

    assign diff    = 17'(x_reg) - 17'($signed(center));
    assign sq_full = 34'($signed(diff) * $signed(diff));
    assign term    = 49'(sq_reg) * 49'(w2_reg);
    assign sum     = 65'(acc_reg) + 65'(term);

    always_comb
    begin
        acc_next = acc_reg;
        if (shift)
        begin
            acc_next = shift_in;
        end
        else if (upd2_reg)
        begin
            acc_next = sum[64] ? '1 : sum[63:0];
            if (clr2_reg)
            begin
                acc_next = acc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg  <= 1'b0;
            upd2_reg <= 1'b0;
            clr_reg  <= 1'b0;
            clr2_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            upd_reg  <= ctl.upd;
            clr_reg  <= ctl.clr;
            upd2_reg <= upd_reg;
            clr2_reg <= clr_reg;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= ctl.x;
        w_reg  <= ctl.w;
        sq_reg <= sq_full[32:0];
        w2_reg <= w_reg;
    end

    assign acc = acc_reg;

endmodule

[rtl/weighted_sq_euclid_distance.sv]
// Top level of the weighted squared Euclidean distance block.
//
// Channel in carries load beats (cmd 0) that write one center element and
// sample beats (cmd 1) that add w*(x-c)^2 into every active cluster cell.
// Channel out delivers one beat per active cluster when a row ends, cluster 0
// first, with last_cluster on the final beat. Channel cfg writes
// cluster_count (index 0) and feature_count (index 1).
// A sample beat runs through a three-stage cell pipeline (center read,
// square, weight multiply with accumulate), so a sample is accepted every
// cycle while the block is not draining or emitting, and the next may follow
// directly. At a row end the block waits in a drain state for the pipeline to
// settle and then shifts the accumulators along the cell chain toward the
// output, one per cycle while the receiver is ready. The final shift clears
// every cell. The rate is set by the drain wait and the shift chain.
// A stalled receiver holds the chain and the input stops accepting.
// Reset clears the accumulators, the row position and both counts to one;
// the center memory is not cleared and must be loaded before use.
module weighted_sq_euclid_distance #(
    parameter int unsigned MAX_CLUSTERS = wsed_pkg::MAX_CLUSTERS_DEF,
    parameter int unsigned MAX_FEATURES = wsed_pkg::MAX_FEATURES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wsed_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output wsed_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [8:0]          cfg_data
);

    localparam int unsigned AW = $clog2(MAX_FEATURES);
    localparam int unsigned CW = $clog2(MAX_CLUSTERS + 1);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  ccount_reg;
    logic [8:0]  fcount_reg;
    logic [7:0]  pos_reg;
    logic [1:0]  drain_reg;
    logic [5:0]  emit_reg;
    logic [CW-1:0] nclu;
    logic [8:0]  nfeat;
    logic        in_fire;
    logic        smp;
    logic        row_end;
    logic [AW-1:0] rpos;
    logic        shift;
    logic [63:0] acc [MAX_CLUSTERS];
    wsed_pkg::cell_ctl_t ctl [MAX_CLUSTERS];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (ccount_reg == 7'd0)
            nclu = CW'(1);
        else if (32'(ccount_reg) > MAX_CLUSTERS)
            nclu = CW'(MAX_CLUSTERS);
        else
            nclu = CW'(ccount_reg);
        if (fcount_reg == 9'd0)
            nfeat = 9'd1;
        else if (32'(fcount_reg) > MAX_FEATURES)
            nfeat = 9'(MAX_FEATURES);
        else
            nfeat = fcount_reg;
    end

    assign in_ready = (state_reg == ST_RUN);
    assign in_fire  = in_valid && in_ready;
    assign smp      = in_fire && (in_data.cmd == wsed_pkg::CMD_SAMPLE);
    assign row_end  = smp && (9'(pos_reg) + 9'd1 >= nfeat);
    assign rpos     = (32'(pos_reg) >= MAX_FEATURES) ? AW'(MAX_FEATURES - 1) : pos_reg[AW-1:0];
    assign out_valid = (state_reg == ST_EMIT);
    assign shift    = out_valid && out_ready;

    assign out_data.result_cluster = emit_reg;
    assign out_data.distance       = acc[0];
    assign out_data.last_cluster   = (7'(emit_reg) + 7'd1 == 7'(nclu));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:   if (row_end) state_next = ST_DRAIN;
            ST_DRAIN: if (drain_reg == 2'd3) state_next = ST_EMIT;
            ST_EMIT:  if (shift && out_data.last_cluster) state_next = ST_RUN;
            default:  state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RUN;
            ccount_reg <= 7'd1;
            fcount_reg <= 9'd1;
            pos_reg    <= '0;
            drain_reg  <= '0;
            emit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == wsed_pkg::REG_CLUSTER_COUNT)
                    ccount_reg <= cfg_data[6:0];
                else
                    fcount_reg <= cfg_data;
            end
            if (row_end)
                pos_reg <= '0;
            else if (smp)
                pos_reg <= pos_reg + 8'd1;
            drain_reg <= (state_reg == ST_DRAIN) ? drain_reg + 2'd1 : 2'd0;
            if (state_reg != ST_EMIT)
                emit_reg <= '0;
            else if (shift)
                emit_reg <= emit_reg + 6'd1;
        end
    end

    for (genvar g = 0; g < MAX_CLUSTERS; g++)
    begin : g_cell
        logic [63:0] nb;
        assign ctl[g].upd = smp && (g < nclu);
        assign ctl[g].clr = 1'b0;
        assign ctl[g].x   = in_data.value;
        assign ctl[g].w   = in_data.weight;
        if (g == MAX_CLUSTERS - 1)
        begin : g_end
            assign nb = '0;
        end
        else
        begin : g_mid
            assign nb = acc[g + 1];
        end
        wsed_cell #(.MAX_FEATURES(MAX_FEATURES)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .we       (in_fire && in_data.cmd == wsed_pkg::CMD_LOAD
                       && 32'(in_data.cluster_index) == g
                       && 32'(in_data.feature_index) < MAX_FEATURES),
            .waddr    (in_data.feature_index[AW-1:0]),
            .wdata    (in_data.value),
            .raddr    (rpos),
            .ctl      (ctl[g]),
            .shift    (shift || (shift == 1'b0 && state_reg == ST_EMIT
                       && 1'b0) || (state_next == ST_RUN && state_reg == ST_EMIT)),
            .shift_in (out_data.last_cluster ? 64'd0 : nb),
            .acc      (acc[g])
        );
    end

endmodule

[rtl/wsed_checker.sv]
// Port-level checker for the weighted squared distance block, with its bind.
module wsed_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input wsed_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat dropped while stalled");

    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while results pending");

    a_cluster_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_cluster |=>
        out_data.result_cluster == $past(out_data.result_cluster) + 6'd1)
        else $error("cluster order broken");

endmodule

bind weighted_sq_euclid_distance wsed_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
